// File: rtl/core/hsrc_pkg.sv
// Shared widths, constants and position tables for the Hamming SEC row codec.
// No dependencies; used by hamming_sec_row_codec and its testbench.
package hsrc_pkg;

   localparam int MAX_DATA_BYTES = 4;
   localparam int MAX_CHECK_BITS = 6;
   localparam int BITS_PER_BYTE  = 8;
   localparam int DATA_W         = MAX_DATA_BYTES * BITS_PER_BYTE;
   localparam int CODE_W         = DATA_W + MAX_CHECK_BITS;
   localparam int SYN_W          = MAX_CHECK_BITS;
   localparam int CFG_W          = 3;
   localparam int ADDR_W         = 3;
   localparam int APB_W          = 32;

   // command codes of the request word
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // register select, taken from the word index bit of paddr
   localparam logic REG_DATA_BYTES = 1'b0;

   localparam logic [CFG_W-1:0] DATA_BYTES_RESET = CFG_W'(MAX_DATA_BYTES);

   // 1-based codeword position of data bit k (the non power-of-two slots)
   localparam logic [SYN_W-1:0] DATA_POS [DATA_W] = '{
      6'd3,  6'd5,  6'd6,  6'd7,  6'd9,  6'd10, 6'd11, 6'd12,
      6'd13, 6'd14, 6'd15, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
      6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
      6'd30, 6'd31, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38
   };

   // positions covered by check bit 2^c: bit q-1 set when (q & 2^c) != 0
   function automatic logic [CODE_W-1:0] check_mask(input int c);
      logic [CODE_W-1:0] m;
      m = '0;
      for (int i = 0; i < CODE_W; i++) begin
         m[i] = 1'(((i + 1) >> c) & 1);
      end
      return m;
   endfunction

endpackage

// File: rtl/core/hamming_sec_row_codec.sv
// Hamming single-error-correcting encoder/decoder for one row of 1..4 bytes.
// Depends on hsrc_pkg for widths, the data position table and parity masks.

// One word per cycle unless a result is held back: an input register
// captures the request word, a single pass of fixed parity trees, syndrome
// compare and correction feeds the result register that drives rsp_*. Both
// stages move unless a result is held back, so a new word is taken every cycle
// while results drain, and an input word is taken even while a finished result
// waits. The data_bytes register (byte address 0, reset 4; 0 acts as 1 and
// 5..7 as 4) sets the codeword length n = 12, 21, 29 or 38. Change it only
// while no word is in flight. Encode returns the codeword with check bits at
// positions 1, 2, 4, ...; decode returns the corrected codeword, the extracted
// data, the syndrome and flags for a corrected bit or a syndrome beyond n.
module hamming_sec_row_codec (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [hsrc_pkg::DATA_W-1:0]  req_data_word,
   input  logic [hsrc_pkg::CODE_W-1:0]  req_code_word,
   input  logic                         req_last_row,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [hsrc_pkg::CODE_W-1:0]  rsp_code_word_out,
   output logic [hsrc_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [hsrc_pkg::SYN_W-1:0]   rsp_syndrome,
   output logic                         rsp_bit_flipped,
   output logic                         rsp_syndrome_out_of_range,
   output logic                         rsp_last_row_out,
   // configuration port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [hsrc_pkg::ADDR_W-1:0]  paddr,
   input  logic [hsrc_pkg::APB_W-1:0]   pwdata,
   output logic [hsrc_pkg::APB_W-1:0]   prdata,
   output logic                         pready
);

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic [hsrc_pkg::CFG_W-1:0] data_bytes_ff, data_bytes_in;
   logic                       reg_sel;

   assign reg_sel = (paddr[2] == hsrc_pkg::REG_DATA_BYTES);
   assign pready  = 1'b1;

   always_comb begin
      data_bytes_in = data_bytes_ff;
      if (psel && penable && pwrite && reg_sel) begin
         data_bytes_in = pwdata[hsrc_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bytes_ff <= hsrc_pkg::DATA_BYTES_RESET;
      end else begin
         data_bytes_ff <= data_bytes_in;
      end
   end

   assign prdata = reg_sel ? {{(hsrc_pkg::APB_W-hsrc_pkg::CFG_W){1'b0}}, data_bytes_ff}
                           : '0;

   // ---------------------------------------------------------------
   // Pipeline flow: both stages move when the result side frees up
   // ---------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s2_load;

   assign s2_load   = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s2_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) s1_valid_in = req_valid;
      s2_valid_in = s2_valid_ff;
      if (s2_load) s2_valid_in = 1'b1;
      else if (rsp_ready) s2_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // input register (payload, no reset)
   logic                        s1_command_ff;
   logic [hsrc_pkg::DATA_W-1:0] s1_data_ff;
   logic [hsrc_pkg::CODE_W-1:0] s1_code_ff;
   logic                        s1_last_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_command_ff <= req_command;
         s1_data_ff    <= req_data_word;
         s1_code_ff    <= req_code_word;
         s1_last_ff    <= req_last_row;
      end
   end

   // ---------------------------------------------------------------
   // Row geometry from data_bytes
   // ---------------------------------------------------------------
   logic [hsrc_pkg::SYN_W-1:0]  code_len;    // n
   logic [2:0]                  row_bytes;   // effective bytes, 1..4
   logic [hsrc_pkg::CODE_W-1:0] code_mask;
   logic [hsrc_pkg::DATA_W-1:0] data_mask;

   always_comb begin
      case (data_bytes_ff) inside
         3'd0, 3'd1: begin code_len = 6'd12; row_bytes = 3'd1; end
         3'd2:       begin code_len = 6'd21; row_bytes = 3'd2; end
         3'd3:       begin code_len = 6'd29; row_bytes = 3'd3; end
         default:    begin code_len = 6'd38; row_bytes = 3'd4; end
      endcase
      for (int i = 0; i < hsrc_pkg::CODE_W; i++) begin
         code_mask[i] = (6'(i) < code_len);
      end
      for (int i = 0; i < hsrc_pkg::DATA_W; i++) begin
         data_mask[i] = (3'(i / hsrc_pkg::BITS_PER_BYTE) < row_bytes);
      end
   end

   // ---------------------------------------------------------------
   // Encode: scatter data MSB first into non power-of-two slots, then
   // drop in the check bits. Slots above n stay zero, so the fixed
   // full-width masks give the same parities as the n-bit sums.
   // ---------------------------------------------------------------
   logic [hsrc_pkg::DATA_W-1:0] enc_data;
   logic [hsrc_pkg::CODE_W-1:0] enc_slots;
   logic [hsrc_pkg::CODE_W-1:0] enc_word;

   always_comb begin
      enc_data  = s1_data_ff & data_mask;
      enc_slots = '0;
      for (int k = 0; k < hsrc_pkg::DATA_W; k++) begin
         enc_slots[hsrc_pkg::DATA_POS[k] - 6'd1] = enc_data[k ^ 7];
      end
      enc_word = enc_slots;
      for (int c = 0; c < hsrc_pkg::MAX_CHECK_BITS; c++) begin
         enc_word[(1 << c) - 1] = ^(enc_slots & hsrc_pkg::check_mask(c));
      end
   end

   // ---------------------------------------------------------------
   // Decode: syndrome, single-bit fix, data gather
   // ---------------------------------------------------------------
   logic [hsrc_pkg::CODE_W-1:0] dec_in;
   logic [hsrc_pkg::SYN_W-1:0]  dec_syn;
   logic                        dec_flip;
   logic                        dec_oor;
   logic [hsrc_pkg::CODE_W-1:0] dec_word;
   logic [hsrc_pkg::DATA_W-1:0] dec_data;

   always_comb begin
      dec_in = s1_code_ff & code_mask;
      for (int c = 0; c < hsrc_pkg::MAX_CHECK_BITS; c++) begin
         dec_syn[c] = ^(dec_in & hsrc_pkg::check_mask(c));
      end
      dec_flip = (dec_syn != '0) && (dec_syn <= code_len);
      dec_oor  = (dec_syn != '0) && (dec_syn > code_len);
      for (int i = 0; i < hsrc_pkg::CODE_W; i++) begin
         dec_word[i] = dec_in[i] ^ (dec_flip && (dec_syn == 6'(i + 1)));
      end
      for (int k = 0; k < hsrc_pkg::DATA_W; k++) begin
         dec_data[k ^ 7] = dec_word[hsrc_pkg::DATA_POS[k] - 6'd1];
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic [hsrc_pkg::CODE_W-1:0] code_out_ff;
   logic [hsrc_pkg::DATA_W-1:0] data_out_ff;
   logic [hsrc_pkg::SYN_W-1:0]  syn_ff;
   logic                        flip_ff;
   logic                        oor_ff;
   logic                        last_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         last_ff <= s1_last_ff;
         if (s1_command_ff == hsrc_pkg::CMD_DECODE) begin
            code_out_ff <= dec_word;
            data_out_ff <= dec_data;
            syn_ff      <= dec_syn;
            flip_ff     <= dec_flip;
            oor_ff      <= dec_oor;
         end else begin
            code_out_ff <= enc_word;
            data_out_ff <= enc_data;
            syn_ff      <= '0;
            flip_ff     <= 1'b0;
            oor_ff      <= 1'b0;
         end
      end
   end

   assign rsp_valid                 = s2_valid_ff;
   assign rsp_code_word_out         = code_out_ff;
   assign rsp_data_out              = data_out_ff;
   assign rsp_syndrome              = syn_ff;
   assign rsp_bit_flipped           = flip_ff;
   assign rsp_syndrome_out_of_range = oor_ff;
   assign rsp_last_row_out          = last_ff;

`ifndef SYNTHESIS
   // a corrected word has a real syndrome and is never also flagged
   a_flip_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bit_flipped |-> rsp_syndrome != '0 && !rsp_syndrome_out_of_range)
      else $error("bit_flipped with zero syndrome or out-of-range flag");

   // a flagged syndrome is nonzero and lies beyond the shortest codeword
   a_oor_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_syndrome_out_of_range |-> rsp_syndrome > 6'd12)
      else $error("out-of-range flag with an in-range syndrome");

   // a held input word is never lost
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff)
      else $error("input stage dropped a word");

   // a load always leaves a result word on the port
   a_s2_source: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> rsp_valid)
      else $error("result stage empty after a load");
`endif

endmodule

// File: dv/hamming_sec_row_codec_tb.sv
// Self-checking testbench for hamming_sec_row_codec: random encode/decode words with
// handshake gaps, checked against an in-bench predictor held by a small scoreboard class.
// Depends on hsrc_pkg (widths, codes, reset value, register select) and the codec RTL.
module hamming_sec_row_codec_tb;

   // byte address of data_bytes: word index in paddr[2], byte offset zero
   localparam logic [hsrc_pkg::ADDR_W-1:0] DATA_BYTES_ADDR = {hsrc_pkg::REG_DATA_BYTES, 2'b00};

   localparam int PIPE_LATENCY   = 4;    // two stages plus margin
   localparam int DRAIN_LIMIT    = 2000; // cycles to wait for outstanding words
   localparam int WORDS_PER_PASS = 146;
   localparam int PASSES         = 12;

   localparam logic [hsrc_pkg::CFG_W-1:0] PASS_SETTING [PASSES] = '{
      3'd2, 3'd3, 3'd0, 3'd5, 3'd1, 3'd4, 3'd6, 3'd7, 3'd3, 3'd2, 3'd4, 3'd1
   };

   typedef struct packed {
      logic [hsrc_pkg::CODE_W-1:0] code_word;
      logic [hsrc_pkg::DATA_W-1:0] data;
      logic [hsrc_pkg::SYN_W-1:0]  syndrome;
      logic                        flipped;
      logic                        out_of_range;
      logic                        last_row;
   } row_result_type;

   // Holds the predictor, its copy of data_bytes, and the words still owed by the DUT.
   class row_scoreboard_type;
      int unsigned                errors;
      logic [hsrc_pkg::CFG_W-1:0] data_bytes;
      row_result_type             owed_q[$];

      function new();
         errors     = 0;
         data_bytes = hsrc_pkg::DATA_BYTES_RESET;
      endfunction

      // 0 acts as 1, 5..7 act as 4
      function int unsigned row_bytes();
         if (data_bytes == 0) return 1;
         if (data_bytes > hsrc_pkg::MAX_DATA_BYTES) return hsrc_pkg::MAX_DATA_BYTES;
         return data_bytes;
      endfunction

      // n = m + floor(log2 m) + 1, which equals m + clog2(m+1) for m = 8, 16, 24, 32
      function int unsigned code_len();
         int unsigned m;
         m = hsrc_pkg::BITS_PER_BYTE * row_bytes();
         return m + $clog2(m + 1);
      endfunction

      function logic [hsrc_pkg::CODE_W-1:0] len_mask();
         logic [hsrc_pkg::CODE_W-1:0] msk;
         msk = '0;
         for (int unsigned q = 0; q < code_len(); q++) msk[q] = 1'b1;
         return msk;
      endfunction

      function bit is_pow2(int unsigned q);
         return q != 0 && (q & (q - 1)) == 0;
      endfunction

      // even parity over every position q in 1..n that check position p covers
      function bit cover_parity(logic [hsrc_pkg::CODE_W-1:0] w, int unsigned n,
                                int unsigned p);
         bit acc;
         acc = 1'b0;
         for (int unsigned q = 1; q <= n; q++)
            if ((q & p) != 0) acc ^= w[q-1];
         return acc;
      endfunction

      function logic [hsrc_pkg::CODE_W-1:0] encode_row(logic [hsrc_pkg::DATA_W-1:0] dw);
         logic [hsrc_pkg::CODE_W-1:0] w;
         int unsigned                 n, k;
         n = code_len();
         k = 0;
         w = '0;
         for (int unsigned q = 1; q <= n; q++) begin
            if (!is_pow2(q)) begin
               // data bit k: byte k/8, MSB first within the byte
               w[q-1] = dw[(k >> 3) * 8 + 7 - (k & 7)];
               k++;
            end
         end
         for (int unsigned p = 1; p <= n; p = p << 1)
            if (cover_parity(w, n, p)) w[p-1] = 1'b1;
         return w;
      endfunction

      function logic [hsrc_pkg::DATA_W-1:0] pull_data(logic [hsrc_pkg::CODE_W-1:0] cw,
                                                       int unsigned n);
         logic [hsrc_pkg::DATA_W-1:0] d;
         int unsigned                 k;
         d = '0;
         k = 0;
         for (int unsigned q = 1; q <= n; q++) begin
            if (!is_pow2(q)) begin
               d[(k >> 3) * 8 + 7 - (k & 7)] = cw[q-1];
               k++;
            end
         end
         return d;
      endfunction

      function row_result_type predict(logic cmd, logic [hsrc_pkg::DATA_W-1:0] dw,
                                       logic [hsrc_pkg::CODE_W-1:0] cw, logic lr);
         row_result_type              res;
         logic [hsrc_pkg::DATA_W-1:0] dmask;
         logic [hsrc_pkg::CODE_W-1:0] rx;
         int unsigned                 n, syn;
         n     = code_len();
         dmask = '0;
         for (int unsigned b = 0; b < hsrc_pkg::BITS_PER_BYTE * row_bytes(); b++)
            dmask[b] = 1'b1;
         res          = '0;
         res.last_row = lr;
         if (cmd == hsrc_pkg::CMD_ENCODE) begin
            res.data      = dw & dmask;
            res.code_word = encode_row(dw & dmask);
         end else begin
            rx  = cw & len_mask();
            syn = 0;
            for (int unsigned p = 1; p <= n; p = p << 1)
               if (cover_parity(rx, n, p)) syn += p;
            if (syn != 0) begin
               if (syn <= n) begin
                  rx[syn-1]   = ~rx[syn-1];
                  res.flipped = 1'b1;
               end else begin
                  res.out_of_range = 1'b1;
               end
            end
            res.syndrome  = hsrc_pkg::SYN_W'(syn);
            res.code_word = rx;
            res.data      = pull_data(rx, n);
         end
         return res;
      endfunction

      function void note_request(logic cmd, logic [hsrc_pkg::DATA_W-1:0] dw,
                                 logic [hsrc_pkg::CODE_W-1:0] cw, logic lr);
         owed_q = {owed_q, predict(cmd, dw, cw, lr)};
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h, want %0h", what, got, want);
         errors++;
      endtask

      task check_result(row_result_type got);
         row_result_type want;
         if (owed_q.size() == 0) begin
            report_mismatch("unexpected result word", 64'(got.code_word), 64'(0));
         end else begin
            want = owed_q.pop_front();
            if (got.code_word !== want.code_word)
               report_mismatch("code_word_out", 64'(got.code_word), 64'(want.code_word));
            if (got.data !== want.data)
               report_mismatch("data_out", 64'(got.data), 64'(want.data));
            if (got.syndrome !== want.syndrome)
               report_mismatch("syndrome", 64'(got.syndrome), 64'(want.syndrome));
            if (got.flipped !== want.flipped)
               report_mismatch("bit_flipped", 64'(got.flipped), 64'(want.flipped));
            if (got.out_of_range !== want.out_of_range)
               report_mismatch("syndrome_out_of_range", 64'(got.out_of_range),
                               64'(want.out_of_range));
            if (got.last_row !== want.last_row)
               report_mismatch("last_row_out", 64'(got.last_row), 64'(want.last_row));
         end
      endtask
   endclass

   // ---------------------------------------------------------------- DUT and signals
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_command = hsrc_pkg::CMD_ENCODE;
   logic [hsrc_pkg::DATA_W-1:0] req_data_word = '0;
   logic [hsrc_pkg::CODE_W-1:0] req_code_word = '0;
   logic                        req_last_row = 1'b0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [hsrc_pkg::CODE_W-1:0] rsp_code_word_out;
   logic [hsrc_pkg::DATA_W-1:0] rsp_data_out;
   logic [hsrc_pkg::SYN_W-1:0]  rsp_syndrome;
   logic                        rsp_bit_flipped;
   logic                        rsp_syndrome_out_of_range;
   logic                        rsp_last_row_out;

   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [hsrc_pkg::ADDR_W-1:0] paddr = '0;
   logic [hsrc_pkg::APB_W-1:0]  pwdata = '0;
   logic [hsrc_pkg::APB_W-1:0]  prdata;
   logic                        pready;

   hamming_sec_row_codec DUT (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_command               (req_command),
      .req_data_word             (req_data_word),
      .req_code_word             (req_code_word),
      .req_last_row              (req_last_row),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_code_word_out         (rsp_code_word_out),
      .rsp_data_out              (rsp_data_out),
      .rsp_syndrome              (rsp_syndrome),
      .rsp_bit_flipped           (rsp_bit_flipped),
      .rsp_syndrome_out_of_range (rsp_syndrome_out_of_range),
      .rsp_last_row_out          (rsp_last_row_out),
      .psel                      (psel),
      .penable                   (penable),
      .pwrite                    (pwrite),
      .paddr                     (paddr),
      .pwdata                    (pwdata),
      .prdata                    (prdata),
      .pready                    (pready)
   );

   row_scoreboard_type sb = new();

   // when set, both sides run without gaps for the current pass
   bit steady_pass = 1'b0;

   always #5 clock = ~clock;

   // Hard stop, far above the slowest legal run
   // (about 1800 words with the longest gaps and stalls, plus config traffic).
   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- monitor
   // Both handshakes are sampled on the rising edge, before any NBA update,
   // so request notes and result checks see the values that made the transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_command, req_data_word, req_code_word, req_last_row);
         if (rsp_valid && rsp_ready)
            sb.check_result(row_result_type'{code_word:    rsp_code_word_out,
                                             data:         rsp_data_out,
                                             syndrome:     rsp_syndrome,
                                             flipped:      rsp_bit_flipped,
                                             out_of_range: rsp_syndrome_out_of_range,
                                             last_row:     rsp_last_row_out});
      end
   end

   function automatic int unsigned draw_wait();
      if (steady_pass) return 0;
      return $urandom_range(0, 6);
   endfunction

   function automatic logic [hsrc_pkg::CODE_W-1:0] rand_code();
      return hsrc_pkg::CODE_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [hsrc_pkg::CODE_W-1:0] flip(logic [hsrc_pkg::CODE_W-1:0] cw,
                                                         int unsigned pos);
      cw[pos-1] = ~cw[pos-1];
      return cw;
   endfunction

   // ---------------------------------------------------------------- result side
   // Draws a stall before each result word, then holds ready until one is taken.
   initial begin
      int unsigned stall;
      wait (reset == 1'b0);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------- request side
   // One word: optional gap with valid low, then valid held with a stable payload
   // until the edge where ready is seen high.
   task automatic send_row(logic cmd, logic [hsrc_pkg::DATA_W-1:0] dw,
                           logic [hsrc_pkg::CODE_W-1:0] cw, logic lr);
      int unsigned gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_data_word <= dw;
      req_code_word <= cw;
      req_last_row  <= lr;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lower valid, let every owed word come back, then let the pipe settle.
   task automatic wait_drained();
      int unsigned guard;
      req_valid <= 1'b0;
      guard = 0;
      @(posedge clock);
      while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (sb.pending() != 0) begin
         sb.report_mismatch("result words never arrived", 64'(sb.pending()), 64'(0));
         sb.owed_q.delete();
      end
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   // APB write of data_bytes (upper pwdata bits random), then read back.
   task automatic set_data_bytes(logic [hsrc_pkg::CFG_W-1:0] value);
      logic [hsrc_pkg::APB_W-1:0] wdata;
      wdata = {$urandom()};
      wdata[hsrc_pkg::CFG_W-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= DATA_BYTES_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.data_bytes = value;
      // read phase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== hsrc_pkg::APB_W'(value))
         sb.report_mismatch("data_bytes readback", 64'(prdata), 64'(value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Random word: mostly clean or lightly damaged codewords of random data, so that
   // correction and extraction are exercised, plus encodes and raw noise.
   task automatic send_random_row();
      logic [hsrc_pkg::DATA_W-1:0] dw;
      logic [hsrc_pkg::CODE_W-1:0] cw;
      int unsigned                 kind, n, pa, pb;
      dw   = $urandom();
      n    = sb.code_len();
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
         send_row(hsrc_pkg::CMD_ENCODE, dw, rand_code(), 1'($urandom()));
      end else if (kind == 9) begin
         send_row(hsrc_pkg::CMD_DECODE, dw, rand_code(), 1'($urandom()));
      end else begin
         // clean codeword with junk above position n
         cw = sb.encode_row(dw) | (rand_code() & ~sb.len_mask());
         pa = $urandom_range(1, n);
         case ($urandom_range(0, 3))
            0: ;                                   // no error
            1, 2: cw = flip(cw, pa);               // single error, corrected
            default: begin                         // double error, may land beyond n
               pb = $urandom_range(1, n);
               if (pb == pa) pb = (pa == n) ? 1 : pa + 1;
               cw = flip(flip(cw, pa), pb);
            end
         endcase
         send_row(hsrc_pkg::CMD_DECODE, $urandom(), cw, 1'($urandom()));
      end
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      logic [hsrc_pkg::CODE_W-1:0] cw;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed, reset width (4 bytes, n = 38)
      steady_pass = 1'b1;
      send_row(hsrc_pkg::CMD_ENCODE, '0, rand_code(), 1'b0);
      send_row(hsrc_pkg::CMD_ENCODE, '1, '0, 1'b1);
      send_row(hsrc_pkg::CMD_ENCODE, 32'h8001_0180, '1, 1'b0);   // MSB and LSB of bytes
      send_row(hsrc_pkg::CMD_DECODE, '1, sb.encode_row('1), 1'b1);
      send_row(hsrc_pkg::CMD_DECODE, '0, '0, 1'b0);
      cw = sb.encode_row(32'h1234_5678);
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(cw, 1), 1'b0);      // check bit error
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(cw, 38), 1'b1);     // last position
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(cw, 3), 1'b0);      // first data position
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(flip(cw, 32), 7), 1'b0);  // syndrome 39
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(flip(cw, 32), 31), 1'b1); // syndrome 63
      send_row(hsrc_pkg::CMD_DECODE, '1, '1, 1'b0);
      wait_drained();

      // directed, one byte (n = 12): junk in unused bytes and above n
      set_data_bytes(3'd1);
      send_row(hsrc_pkg::CMD_ENCODE, '1, '1, 1'b0);
      cw = sb.encode_row(32'h0000_00A5) | ~sb.len_mask();
      send_row(hsrc_pkg::CMD_DECODE, '1, cw, 1'b1);
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(cw, 12), 1'b0);
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(flip(cw, 8), 5), 1'b0);   // syndrome 13
      send_row(hsrc_pkg::CMD_DECODE, '0, flip(flip(cw, 8), 7), 1'b1);   // syndrome 15
      wait_drained();

      // register value 0 behaves as one byte, 7 as four
      set_data_bytes(3'd0);
      send_row(hsrc_pkg::CMD_ENCODE, 32'hFFFF_FF5A, '0, 1'b0);
      wait_drained();
      set_data_bytes(3'd7);
      send_row(hsrc_pkg::CMD_DECODE, '0, '1, 1'b1);
      wait_drained();

      // random passes, one setting each, some without any handshake gaps
      for (int i = 0; i < PASSES; i++) begin
         set_data_bytes(PASS_SETTING[i]);
         steady_pass = ($urandom_range(0, 3) == 0);
         repeat (WORDS_PER_PASS) send_random_row();
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: hamming_sec_row_codec.f
rtl/core/hsrc_pkg.sv
rtl/core/hamming_sec_row_codec.sv
dv/hamming_sec_row_codec_tb.sv
